### hdl/bis_pkg.sv
// ---------------------------------------------------------------------------
// Bilinear image scaler package
// Shared widths, register indexes, opcodes and controller/datapath types.
// ---------------------------------------------------------------------------
package bis_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_H_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_V_STEP = 3'd5;

  // register widths
  localparam int SRC_DIM_W = 9;
  localparam int TGT_DIM_W = 13;
  localparam int STEP_W    = 24;

  localparam logic [SRC_DIM_W-1:0] RST_SRC_DIM = 9'd256;
  localparam logic [TGT_DIM_W-1:0] RST_TGT_DIM = 13'd256;
  localparam logic [STEP_W-1:0]    RST_STEP    = 24'd65536;

  localparam int TGT_MIN = 2;
  localparam int TGT_MAX = 4096;

  // 8.16 source coordinate accumulators
  localparam int COORD_ACC_W = 24;
  localparam int FRAC_W      = 16;

  // target position counters
  localparam int POS_W = 12;

  // frame store
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // pixel layout: red 7:0, green 15:8, blue 23:16, alpha 31:24
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 4;
  localparam int PIX_W    = CHAN_W * NUM_CHAN;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef struct packed {
    logic       load_we;  // write the incoming source pixel
    logic       calc_en;  // latch neighbor coordinates and fractions
    logic       base_en;  // latch row bases and corner weights
    logic       rd_en;    // read one neighbor from the store
    logic [1:0] rd_sel;   // which neighbor
    logic       commit;   // write output register, step counters
  } bis_cmd_t;

  typedef struct packed {
    logic out_free;       // output register can take a result this cycle
  } bis_status_t;

endpackage

### hdl/bis_ctrl.sv
// ---------------------------------------------------------------------------
// Bilinear image scaler controller
// Issues loads; each emit runs setup, four store reads, a drain and commit.
// ---------------------------------------------------------------------------
module bis_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  bis_pkg::bis_status_t status_i,
  output bis_pkg::bis_cmd_t    cmd_o
);
  import bis_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CALC  = 4'd1;
  localparam logic [3:0] S_BASE  = 4'd2;
  localparam logic [3:0] S_RD0   = 4'd3;
  localparam logic [3:0] S_RD1   = 4'd4;
  localparam logic [3:0] S_RD2   = 4'd5;
  localparam logic [3:0] S_RD3   = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_we = in_valid_i && (opcode_i == OP_LOAD);
        if (in_valid_i && (opcode_i == OP_EMIT)) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc_en = 1'b1;
        state_d       = S_BASE;
      end
      S_BASE: begin
        cmd_o.base_en = 1'b1;
        state_d       = S_RD0;
      end
      S_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = 2'd0;
        state_d      = S_RD1;
      end
      S_RD1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = 2'd1;
        state_d      = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = 2'd2;
        state_d      = S_RD3;
      end
      S_RD3: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = 2'd3;
        state_d      = S_DRAIN;
      end
      S_DRAIN: begin
        // last neighbor is being accumulated
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> status_i.out_free)
    else $error("commit while output register is occupied");

  a_calc_then_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.calc_en |=> cmd_o.base_en)
    else $error("setup sequence broken");

  a_last_read_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && cmd_o.rd_sel == 2'd3) |=> (!cmd_o.rd_en && !in_ready_o))
    else $error("no drain cycle after last neighbor read");

  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !status_i.out_free) |=> (state_q == S_DONE))
    else $error("left done state without committing");
`endif

endmodule

### hdl/bis_datapath.sv
// ---------------------------------------------------------------------------
// Bilinear image scaler datapath
// Config registers, frame store, coordinate stepping, weighted accumulate.
// ---------------------------------------------------------------------------
module bis_datapath #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int WEIGHT_BITS       = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bis_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [bis_pkg::CHAN_W-1:0]       in_red_i,
  input  logic [bis_pkg::CHAN_W-1:0]       in_green_i,
  input  logic [bis_pkg::CHAN_W-1:0]       in_blue_i,
  input  logic [bis_pkg::CHAN_W-1:0]       in_alpha_i,
  input  bis_pkg::bis_cmd_t                cmd_i,
  output bis_pkg::bis_status_t             status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [bis_pkg::CHAN_W-1:0]       out_red_o,
  output logic [bis_pkg::CHAN_W-1:0]       out_green_o,
  output logic [bis_pkg::CHAN_W-1:0]       out_blue_o,
  output logic [bis_pkg::CHAN_W-1:0]       out_alpha_o,
  output logic [bis_pkg::POS_W-1:0]        out_column_o,
  output logic [bis_pkg::POS_W-1:0]        out_row_o,
  output logic                             frame_end_o
);
  import bis_pkg::*;

  localparam int XW     = $clog2(MAX_SOURCE_WIDTH);
  localparam int YW     = $clog2(MAX_SOURCE_HEIGHT);
  localparam int SWV_W  = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int SHV_W  = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int WW     = 2 * WEIGHT_BITS + 1;
  localparam int SUM_W  = CHAN_W + WW;
  localparam int SHIFT  = 2 * WEIGHT_BITS;
  localparam logic [WEIGHT_BITS:0] ONE_W = {1'b1, {WEIGHT_BITS{1'b0}}};

  // ---------------- configuration registers
  logic [SRC_DIM_W-1:0] src_w_q, src_h_q;
  logic [TGT_DIM_W-1:0] tgt_w_q, tgt_h_q;
  logic [STEP_W-1:0]    h_step_q, v_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= RST_SRC_DIM;
      src_h_q  <= RST_SRC_DIM;
      tgt_w_q  <= RST_TGT_DIM;
      tgt_h_q  <= RST_TGT_DIM;
      h_step_q <= RST_STEP;
      v_step_q <= RST_STEP;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SRC_W:  src_w_q  <= cfg_data_i[SRC_DIM_W-1:0];
        CFG_SRC_H:  src_h_q  <= cfg_data_i[SRC_DIM_W-1:0];
        CFG_TGT_W:  tgt_w_q  <= cfg_data_i[TGT_DIM_W-1:0];
        CFG_TGT_H:  tgt_h_q  <= cfg_data_i[TGT_DIM_W-1:0];
        CFG_H_STEP: h_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_V_STEP: v_step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- effective sizes
  logic [31:0]      sw_ext, sh_ext, tw_ext, th_ext;
  logic [SWV_W-1:0] sw;
  logic [SHV_W-1:0] sh;
  logic [POS_W-1:0] tw_m1, th_m1;

  always_comb begin
    sw_ext = 32'(src_w_q);
    if (sw_ext == 32'd0) begin
      sw_ext = 32'd1;
    end else if (sw_ext > 32'(MAX_SOURCE_WIDTH)) begin
      sw_ext = 32'(MAX_SOURCE_WIDTH);
    end
    sh_ext = 32'(src_h_q);
    if (sh_ext == 32'd0) begin
      sh_ext = 32'd1;
    end else if (sh_ext > 32'(MAX_SOURCE_HEIGHT)) begin
      sh_ext = 32'(MAX_SOURCE_HEIGHT);
    end
    tw_ext = 32'(tgt_w_q);
    if (tw_ext < 32'(TGT_MIN)) begin
      tw_ext = 32'(TGT_MIN);
    end else if (tw_ext > 32'(TGT_MAX)) begin
      tw_ext = 32'(TGT_MAX);
    end
    th_ext = 32'(tgt_h_q);
    if (th_ext < 32'(TGT_MIN)) begin
      th_ext = 32'(TGT_MIN);
    end else if (th_ext > 32'(TGT_MAX)) begin
      th_ext = 32'(TGT_MAX);
    end
  end

  assign sw    = sw_ext[SWV_W-1:0];
  assign sh    = sh_ext[SHV_W-1:0];
  assign tw_m1 = POS_W'(tw_ext - 32'd1);
  assign th_m1 = POS_W'(th_ext - 32'd1);

  // ---------------- load position
  logic [ADDR_W-1:0]      load_pos_q, load_pos_d, load_pos_inc;
  logic [SWV_W+SHV_W-1:0] area;

  assign area         = sw * sh;
  assign load_pos_inc = load_pos_q + ADDR_W'(1);
  assign load_pos_d   = (32'(load_pos_inc) >= 32'(area)) ? '0 : load_pos_inc;

  // ---------------- emit position and source coordinates
  logic [POS_W-1:0]       col_q, row_q;
  logic [COORD_ACC_W-1:0] x_acc_q, y_acc_q;
  logic                   last_col, last_row;

  assign last_col = (col_q >= tw_m1);
  assign last_row = (row_q >= th_m1);

  logic [31:0]            xi_ext, yi_ext, sw_m1, sh_m1;
  logic [31:0]            x0_c, x1_c, y0_c, y1_c;
  logic [WEIGHT_BITS-1:0] wa_c, wb_c;

  always_comb begin
    sw_m1 = sw_ext - 32'd1;
    sh_m1 = sh_ext - 32'd1;
    xi_ext = 32'(x_acc_q[COORD_ACC_W-1:FRAC_W]);
    yi_ext = 32'(y_acc_q[COORD_ACC_W-1:FRAC_W]);
    x0_c = (xi_ext > sw_m1) ? sw_m1 : xi_ext;
    y0_c = (yi_ext > sh_m1) ? sh_m1 : yi_ext;
    x1_c = (x0_c + 32'd1 > sw_m1) ? sw_m1 : x0_c + 32'd1;
    y1_c = (y0_c + 32'd1 > sh_m1) ? sh_m1 : y0_c + 32'd1;
    wa_c = x_acc_q[FRAC_W-1 -: WEIGHT_BITS];
    wb_c = y_acc_q[FRAC_W-1 -: WEIGHT_BITS];
    if (last_col && last_row) begin
      // final pixel copies the bottom-right source corner
      x0_c = sw_m1;
      x1_c = sw_m1;
      y0_c = sh_m1;
      y1_c = sh_m1;
      wa_c = '0;
      wb_c = '0;
    end else if (last_col) begin
      x1_c = x0_c;
      wa_c = '0;
    end else if (last_row) begin
      y1_c = y0_c;
      wb_c = '0;
    end
  end

  // ---------------- setup registers
  logic [XW-1:0]          x0_q, x1_q;
  logic [YW-1:0]          y0_q, y1_q;
  logic [WEIGHT_BITS-1:0] wa_q, wb_q;
  logic                   last_col_q, last_row_q;
  logic [ADDR_W-1:0]      rb0_q, rb1_q;
  logic [WW-1:0]          w_q [NUM_CHAN];

  logic [YW+SWV_W-1:0]    rb0_prod, rb1_prod;
  logic [WEIGHT_BITS:0]   inv_wa, inv_wb, wa_ext, wb_ext;
  logic [2*WEIGHT_BITS+1:0] w00, w01, w10, w11;

  assign rb0_prod = y0_q * sw;
  assign rb1_prod = y1_q * sw;
  assign wa_ext   = {1'b0, wa_q};
  assign wb_ext   = {1'b0, wb_q};
  assign inv_wa   = ONE_W - wa_ext;
  assign inv_wb   = ONE_W - wb_ext;
  assign w00      = inv_wa * inv_wb;
  assign w01      = wa_ext * inv_wb;
  assign w10      = inv_wa * wb_ext;
  assign w11      = wa_ext * wb_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      x0_q       <= x0_c[XW-1:0];
      x1_q       <= x1_c[XW-1:0];
      y0_q       <= y0_c[YW-1:0];
      y1_q       <= y1_c[YW-1:0];
      wa_q       <= wa_c;
      wb_q       <= wb_c;
      last_col_q <= last_col;
      last_row_q <= last_row;
    end
    if (cmd_i.base_en) begin
      rb0_q  <= ADDR_W'(rb0_prod);
      rb1_q  <= ADDR_W'(rb1_prod);
      w_q[0] <= WW'(w00);
      w_q[1] <= WW'(w01);
      w_q[2] <= WW'(w10);
      w_q[3] <= WW'(w11);
    end
  end

  // ---------------- frame store, single port
  logic [PIX_W-1:0]  store_q [STORE_DEPTH];
  logic [PIX_W-1:0]  rdata_q;
  logic [ADDR_W-1:0] rd_addr, mem_addr;

  assign rd_addr  = (cmd_i.rd_sel[1] ? rb1_q : rb0_q)
                  + ADDR_W'(cmd_i.rd_sel[0] ? x1_q : x0_q);
  assign mem_addr = cmd_i.load_we ? load_pos_q : rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      store_q[mem_addr] <= {in_alpha_i, in_blue_i, in_green_i, in_red_i};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_q[mem_addr];
    end
  end

  // ---------------- weighted accumulate, one neighbor per cycle
  logic       rd_valid_q;
  logic [1:0] rd_sel_q;
  logic [SUM_W-1:0] acc_q  [NUM_CHAN];
  logic [SUM_W-1:0] prod   [NUM_CHAN];
  logic [SUM_W-1:0] acc_in [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod[c]   = rdata_q[c*CHAN_W +: CHAN_W] * w_q[rd_sel_q];
      acc_in[c] = (rd_sel_q == 2'd0) ? '0 : acc_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        acc_q[c] <= acc_in[c] + prod[c];
      end
    end
    if (cmd_i.rd_en) begin
      rd_sel_q <= cmd_i.rd_sel;
    end
  end

  // ---------------- truncate and saturate
  logic [CHAN_W-1:0]      chan_out [NUM_CHAN];
  logic [SUM_W-SHIFT-1:0] chan_sh  [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan_sh[c]  = acc_q[c][SUM_W-1:SHIFT];
      chan_out[c] = (chan_sh[c] > (SUM_W-SHIFT)'(CHAN_MAX)) ? CHAN_MAX
                                                            : chan_sh[c][CHAN_W-1:0];
    end
  end

  // ---------------- output register
  logic out_valid_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_red_o    <= chan_out[0];
      out_green_o  <= chan_out[1];
      out_blue_o   <= chan_out[2];
      out_alpha_o  <= chan_out[3];
      out_column_o <= col_q;
      out_row_o    <= row_q;
      frame_end_o  <= last_col_q && last_row_q;
    end
  end

  // ---------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.rd_en;
      if (cmd_i.load_we) begin
        load_pos_q <= load_pos_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        if (last_col_q) begin
          col_q   <= '0;
          x_acc_q <= '0;
          if (last_row_q) begin
            row_q   <= '0;
            y_acc_q <= '0;
          end else begin
            row_q   <= row_q + POS_W'(1);
            y_acc_q <= y_acc_q + v_step_q;
          end
        end else begin
          col_q   <= col_q + POS_W'(1);
          x_acc_q <= x_acc_q + h_step_q;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load_we && cmd_i.rd_en))
    else $error("store write and read in the same cycle");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");
`endif

endmodule

### hdl/bilinear_image_scaler.sv
// An emit transfer runs through coordinate and weight setup, four neighbor reads
//   through the single frame store port, a drain state and the commit, which writes
//   the output register. Loads and new emits are accepted only while idle.
// A waiting output result does not block loads; the next emit stalls only at commit.
// Reset (async, active low) clears counters, coordinate accumulators and config to
//   defaults; the frame store is not cleared and holds nothing valid until loaded.
// ---------------------------------------------------------------------------
// Bilinear image scaler
// RGBA frame store loaded in raster order, bilinear resampled on emit.
// ---------------------------------------------------------------------------
module bilinear_image_scaler #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 256,
  parameter int WEIGHT_BITS       = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [bis_pkg::CHAN_W-1:0]     in_red_i,
  input  logic [bis_pkg::CHAN_W-1:0]     in_green_i,
  input  logic [bis_pkg::CHAN_W-1:0]     in_blue_i,
  input  logic [bis_pkg::CHAN_W-1:0]     in_alpha_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [bis_pkg::CHAN_W-1:0]     out_red_o,
  output logic [bis_pkg::CHAN_W-1:0]     out_green_o,
  output logic [bis_pkg::CHAN_W-1:0]     out_blue_o,
  output logic [bis_pkg::CHAN_W-1:0]     out_alpha_o,
  output logic [bis_pkg::POS_W-1:0]      out_column_o,
  output logic [bis_pkg::POS_W-1:0]      out_row_o,
  output logic                           frame_end_o
);
  import bis_pkg::*;

  bis_cmd_t    cmd;
  bis_status_t status;

  // config registers take a transfer every cycle
  assign cfg_ready_o = 1'b1;

  bis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bis_datapath #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .WEIGHT_BITS       (WEIGHT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_red_i     (in_red_i),
    .in_green_i   (in_green_i),
    .in_blue_i    (in_blue_i),
    .in_alpha_i   (in_alpha_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .out_alpha_o  (out_alpha_o),
    .out_column_o (out_column_o),
    .out_row_o    (out_row_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
